>>> hw/rtl/idsrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsrt_pkg
// Shared types and constants of the identity and secret registration table.
// ----------------------------------------------------------------------------
package idsrt_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;

    // s_tdata: request_key, query_id, query_secret
    localparam int S_DATA_W = 96;
    // m_tdata: status, issued_id, issued_secret, zero fill up to whole bytes
    localparam int M_DATA_W = 72;
    localparam int M_USED_W = STATUS_W + 2 * WORD_W;

    typedef enum logic {
        FUNC_REGISTER = 1'b0,
        FUNC_CHECK    = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_KEY   = 3'd1,
        STATUS_DUPLICATE = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } idsrt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic key_ok;
        logic scan_done;
    } idsrt_stat_t;

endpackage

>>> hw/rtl/idsrt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsrt_dp
// Datapath: key register, seed counters, pair memories, scan compare and
// result register.
// ----------------------------------------------------------------------------
module idsrt_dp
    import idsrt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WORD_W-1:0]   cfg_wr_data,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  idsrt_cmd_t          cmd,
    output idsrt_stat_t         stat,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    logic [WORD_W-1:0] kernel_key_reg;
    logic [WORD_W-1:0] id_seed_reg, id_seed_next;
    logic [WORD_W-1:0] secret_seed_reg, secret_seed_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  addr_reg;
    logic              pend_reg;
    logic              hit_reg;
    logic              key_ok_reg;
    func_t             func_reg;
    logic [WORD_W-1:0] qid_reg;
    logic [WORD_W-1:0] qsec_reg;
    logic [WORD_W-1:0] rd_id_reg;
    logic [WORD_W-1:0] rd_sec_reg;

    logic [WORD_W-1:0] id_mem  [ENTRIES];
    logic [WORD_W-1:0] sec_mem [ENTRIES];

    logic              granted_reg;
    status_t           status_reg;
    logic [WORD_W-1:0] issued_id_reg;
    logic [WORD_W-1:0] issued_sec_reg;

    logic              in_key_ok;
    logic              match;
    logic              scan_active;
    logic              write_en;
    logic              res_granted;
    status_t           res_status;

    assign in_key_ok   = (s_tdata[WORD_W-1:0] == kernel_key_reg);
    assign scan_active = (addr_reg != count_reg);

    always_comb begin
        id_seed_next     = id_seed_reg;
        secret_seed_next = secret_seed_reg;
        if (cmd.load && in_key_ok && (func_t'(s_tuser) == FUNC_REGISTER)) begin
            id_seed_next     = id_seed_reg + 1'b1;
            secret_seed_next = secret_seed_reg + 1'b1;
        end
    end

    // registration looks for the new identity, a check for the full pair
    always_comb begin
        if (func_reg == FUNC_REGISTER) begin
            match = (rd_id_reg == id_seed_reg);
        end else begin
            match = (rd_id_reg == qid_reg) && (rd_sec_reg == qsec_reg);
        end
    end

    always_comb begin
        res_granted = 1'b0;
        res_status  = STATUS_OK;
        write_en    = 1'b0;
        if (!key_ok_reg) begin
            res_status = STATUS_BAD_KEY;
        end else if (func_reg == FUNC_REGISTER) begin
            if (hit_reg) begin
                res_status = STATUS_DUPLICATE;
            end else if (count_reg == FULL_COUNT) begin
                res_status = STATUS_FULL;
            end else begin
                res_granted = 1'b1;
                write_en    = cmd.finish;
            end
        end else if (hit_reg) begin
            res_granted = 1'b1;
        end else begin
            res_status = STATUS_NOT_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_key_reg  <= '0;
            id_seed_reg     <= '0;
            secret_seed_reg <= '0;
            count_reg       <= '0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            key_ok_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                kernel_key_reg <= cfg_wr_data;
            end
            id_seed_reg     <= id_seed_next;
            secret_seed_reg <= secret_seed_next;
            if (cmd.load) begin
                key_ok_reg <= in_key_ok;
                addr_reg   <= '0;
                pend_reg   <= 1'b0;
                hit_reg    <= 1'b0;
            end else if (cmd.scan) begin
                // read data lands in the cycle after its address
                hit_reg  <= hit_reg | (pend_reg & match);
                pend_reg <= scan_active;
                if (scan_active) begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
            if (write_en) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(s_tuser);
            qid_reg  <= s_tdata[2*WORD_W-1:WORD_W];
            qsec_reg <= s_tdata[3*WORD_W-1:2*WORD_W];
        end
    end

    // pair memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (write_en) begin
            id_mem[count_reg[IDX_W-1:0]]  <= id_seed_reg;
            sec_mem[count_reg[IDX_W-1:0]] <= secret_seed_reg;
        end
        if (cmd.scan && scan_active) begin
            rd_id_reg  <= id_mem[addr_reg[IDX_W-1:0]];
            rd_sec_reg <= sec_mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            granted_reg    <= res_granted;
            status_reg     <= res_status;
            issued_id_reg  <= res_granted && (func_reg == FUNC_REGISTER) ? id_seed_reg : '0;
            issued_sec_reg <= res_granted && (func_reg == FUNC_REGISTER) ? secret_seed_reg : '0;
        end
    end

    assign stat.key_ok    = key_ok_reg;
    assign stat.scan_done = !scan_active && !pend_reg;

    assign m_tuser = granted_reg;
    assign m_tdata = {{(M_DATA_W - M_USED_W){1'b0}}, issued_sec_reg, issued_id_reg, status_reg};

endmodule

>>> hw/rtl/idsrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsrt_ctrl
// Controller: accepts a request, sequences the table scan and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module idsrt_ctrl
    import idsrt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output idsrt_cmd_t  cmd,
    input  idsrt_stat_t stat
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd.load   = (state_reg == IDLE) && s_tvalid;
        cmd.scan   = (state_reg == SCAN) && stat.key_ok;
        cmd.finish = (state_reg == FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= SCAN;
                    end
                end
                SCAN: begin
                    // a refused key skips the table
                    if (!stat.key_ok || stat.scan_done) begin
                        state_reg <= FINISH;
                    end
                end
                FINISH: begin
                    if (out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !m_tvalid || m_tready)
        else $error("result register overwritten before transfer");
`endif

endmodule

>>> hw/rtl/id_secret_registration_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_secret_registration_table
// Table of identity and secret pairs, served only to the kernel key.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en / cfg_wr_data write the kernel key; write it only while idle.
//   Each request on the s_ channel gives exactly one result on the m_ channel.
//   A register request with the kernel key advances both seeds and appends
//   the new pair unless the identity is already stored or the table is full;
//   a check request searches for the given identity and secret.
// Timing:
//   The table is scanned one entry per cycle through a registered memory
//   read. One request is in work at a time; the next is taken after its
//   result is loaded.
// Reset:
//   Synchronous, active low: key, seeds and entry count clear to zero, the
//   table is empty. No clearing pass is needed.
// Stall:
//   While m_tready is low the result register holds; a further finished
//   result waits in the controller and s_tready stays low.
// ----------------------------------------------------------------------------
module id_secret_registration_table
    import idsrt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WORD_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // request_key, query_id, query_secret
    input  logic                s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // status, issued_id, issued_secret, zero fill
    output logic                m_tuser    // granted
);

    idsrt_cmd_t  cmd;
    idsrt_stat_t stat;

    idsrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    idsrt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
